>>> hw/rtl/text_mode_console_writer_top_macros.svh
// Assertion macros for the text-mode console writer.
// Included by the RTL file that carries concurrent assertions; no dependencies.
`ifndef TEXT_MODE_CONSOLE_WRITER_TOP_MACROS_SVH
`define TEXT_MODE_CONSOLE_WRITER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Property checked on every rising edge outside of reset.
`define TMCW_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Property checked on every rising edge, reset included.
`define TMCW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TMCW_ASSERT(lbl, clk, rstn, prop, msg)
`define TMCW_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> hw/rtl/tmcw_pkg.sv
// Shared types and constants of the text-mode console writer.
// No dependencies; imported by every other file of the block but the macro header.
package tmcw_pkg;

  // Size of the cell store. The effective column and row counts are clamped to it,
  // and the field widths below are sized for it.
  localparam int MAX_COLUMNS = 80;
  localparam int MAX_ROWS    = 50;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 6;
  localparam int LIN_W  = 13;
  localparam int ATTR_W = 8;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 12;
  localparam int LOC_W  = 12;
  localparam int CELL_W = 16;

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic [1:0] REG_COLUMNS   = 2'd0;
  localparam logic [1:0] REG_ROWS      = 2'd1;
  localparam logic [1:0] REG_ATTRIBUTE = 2'd2;

  localparam logic [COL_W-1:0]  COLUMNS_RST = 7'd80;
  localparam logic [ROW_W-1:0]  ROWS_RST    = 6'd25;
  localparam logic [ATTR_W-1:0] ATTR_RST    = 8'd15;

  localparam logic OP_PUT  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam int TAB_STEP = 8;
  localparam int TAB_MASK = 8 - 1;

  typedef struct packed {
    logic [COL_W-1:0]  ncol;
    logic [ROW_W-1:0]  nrow;
    logic [ATTR_W-1:0] attr;
  } geom_t;

  typedef struct packed {
    logic              operation;
    logic [CHAR_W-1:0] character;
    logic [IDX_W-1:0]  cell_index;
  } item_t;

  typedef struct packed {
    logic              valid;
    logic [LOC_W-1:0]  cursor_location;
    logic [CELL_W-1:0] cell_value;
    logic [CHAR_W-1:0] echoed_char;
  } result_t;

endpackage

>>> hw/rtl/tmcw_if.sv
// Valid/ready channel interfaces of the text-mode console writer.
// Depends on tmcw_pkg for the field widths.
interface tmcw_in_if import tmcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              operation;
  logic [CHAR_W-1:0] character;
  logic [IDX_W-1:0]  cell_index;

  modport source (output valid, operation, character, cell_index, input ready);
  modport sink (input valid, operation, character, cell_index, output ready);
endinterface

interface tmcw_out_if import tmcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [LOC_W-1:0]  cursor_location;
  logic [CELL_W-1:0] cell_value;
  logic [CHAR_W-1:0] echoed_char;

  modport source (output valid, cursor_location, cell_value, echoed_char, input ready);
  modport sink (input valid, cursor_location, cell_value, echoed_char, output ready);
endinterface

>>> hw/rtl/tmcw_mac.sv
// Shared multiply-add unit: q = a * b + c, registered.
// Depends on tmcw_pkg for the operand widths.
module tmcw_mac import tmcw_pkg::*; (
  input  logic             clk_i,
  input  logic [ROW_W-1:0] a_i,
  input  logic [COL_W-1:0] b_i,
  input  logic [LIN_W-1:0] c_i,
  output logic [LIN_W-1:0] q_o
);

  logic [LIN_W-1:0] q_d;
  logic [LIN_W-1:0] q_q;

  assign q_d = (LIN_W'(a_i) * LIN_W'(b_i)) + c_i;

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

  assign q_o = q_q;

endmodule

>>> hw/rtl/tmcw_cell_ram.sv
// Screen cell memory: one write port, one read port with registered data.
// Depends on tmcw_pkg for the cell width.
module tmcw_cell_ram import tmcw_pkg::*; #(
  parameter int DEPTH = 4000,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [CELL_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [CELL_W-1:0] rdata_o
);

  logic [CELL_W-1:0] mem_q [DEPTH];
  logic [CELL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/tmcw_engine.sv
// Sequencer of the console writer: cursor logic, scroll and clear sweeps.
// Depends on tmcw_pkg, tmcw_mac, tmcw_cell_ram and the assertion macro header.
`include "text_mode_console_writer_top_macros.svh"

module tmcw_engine import tmcw_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  geom_t   geom_i,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  item_t   item_i,
  input  logic    res_ready_i,
  output result_t res_o
);

  localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
  localparam int AW         = $clog2(CELL_COUNT);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PUT_WRITE,
    ST_SCR_CALC,
    ST_SCR_INIT,
    ST_SCR_COPY,
    ST_SCR_FILL,
    ST_LOC,
    ST_DONE
  } state_e;

  state_e           state_q;
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic [AW-1:0]    clr_q;
  logic             cp_v_q;

  logic              op_q;
  logic [CHAR_W-1:0] char_q;
  logic              idx_ok_q;
  logic [COL_W:0]    col_tmp_q;
  logic [ROW_W:0]    row_tmp_q;
  logic              wr_ok_q;
  logic [LIN_W-1:0]  i_q;
  logic [LIN_W-1:0]  keep_q;
  logic [LIN_W-1:0]  total_q;
  logic [LIN_W-1:0]  cp_addr_q;

  logic              accept;
  logic              idx_ok;
  logic [COL_W:0]    col_ext;
  logic [ROW_W:0]    row_ext;
  logic [COL_W:0]    col_tmp_d;
  logic [ROW_W:0]    row_tmp_d;
  logic              wr_ok_d;
  logic              wrap;
  logic [COL_W-1:0]  col_w;
  logic [ROW_W:0]    row_w;
  logic              scroll;

  logic [ROW_W-1:0]  mac_a;
  logic [LIN_W-1:0]  mac_c;
  logic [LIN_W-1:0]  mac_q;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [CELL_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [CELL_W-1:0] mem_rdata;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign idx_ok     = (32'(item_i.cell_index) < 32'(CELL_COUNT));

  // Cursor move of a put item, before the wrap and scroll checks.
  assign col_ext = {1'b0, col_q};
  assign row_ext = {1'b0, row_q};

  always_comb begin
    col_tmp_d = col_ext;
    row_tmp_d = row_ext;
    wr_ok_d   = 1'b0;
    unique case (item_i.character)
      CH_BS: begin
        if (col_q != '0) begin
          col_tmp_d = col_ext - (COL_W+1)'(1);
        end
      end
      CH_TAB: begin
        col_tmp_d = (col_ext + (COL_W+1)'(TAB_STEP)) & ~(COL_W+1)'(TAB_MASK);
      end
      CH_CR: begin
        col_tmp_d = '0;
      end
      CH_LF: begin
        col_tmp_d = '0;
        row_tmp_d = row_ext + (ROW_W+1)'(1);
      end
      default: begin
        if (item_i.character >= CH_SPACE) begin
          col_tmp_d = col_ext + (COL_W+1)'(1);
          wr_ok_d   = (col_q < geom_i.ncol) && (row_q < geom_i.nrow);
        end
      end
    endcase
  end

  assign wrap   = (col_tmp_q >= {1'b0, geom_i.ncol});
  assign col_w  = wrap ? '0 : col_tmp_q[COL_W-1:0];
  assign row_w  = wrap ? (row_tmp_q + (ROW_W+1)'(1)) : row_tmp_q;
  assign scroll = (row_w >= {1'b0, geom_i.nrow});

  // The multiply-add unit forms either a cell address from the cursor or the
  // size of the screen in cells.
  always_comb begin
    mac_a = row_q;
    mac_c = LIN_W'(col_q);
    if (state_q == ST_SCR_CALC) begin
      mac_a = geom_i.nrow - ROW_W'(1);
      mac_c = LIN_W'(geom_i.ncol);
    end
  end

  tmcw_mac u_mac (
    .clk_i (clk_i),
    .a_i   (mac_a),
    .b_i   (geom_i.ncol),
    .c_i   (mac_c),
    .q_o   (mac_q)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
      end
      ST_IDLE: begin
        mem_re    = accept && (item_i.operation == OP_READ) && idx_ok;
        mem_raddr = AW'(item_i.cell_index);
      end
      ST_PUT_WRITE: begin
        mem_we    = wr_ok_q;
        mem_waddr = AW'(mac_q);
        mem_wdata = {geom_i.attr, char_q};
      end
      ST_SCR_COPY: begin
        mem_re    = (i_q != keep_q);
        mem_raddr = AW'(i_q + LIN_W'(geom_i.ncol));
        mem_we    = cp_v_q;
        mem_waddr = AW'(cp_addr_q);
        mem_wdata = mem_rdata;
      end
      ST_SCR_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(i_q);
        mem_wdata = {geom_i.attr, CH_SPACE};
      end
      default: begin
      end
    endcase
  end

  tmcw_cell_ram #(
    .DEPTH (CELL_COUNT),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      col_q   <= '0;
      row_q   <= '0;
      clr_q   <= '0;
      cp_v_q  <= 1'b0;
    end else begin
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(CELL_COUNT - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state_q <= (item_i.operation == OP_READ) ? ST_DONE : ST_PUT_WRITE;
          end
        end
        ST_PUT_WRITE: begin
          col_q <= col_w;
          if (scroll) begin
            row_q   <= geom_i.nrow - ROW_W'(1);
            state_q <= ST_SCR_CALC;
          end else begin
            row_q   <= row_w[ROW_W-1:0];
            state_q <= ST_LOC;
          end
        end
        ST_SCR_CALC: begin
          state_q <= ST_SCR_INIT;
        end
        ST_SCR_INIT: begin
          state_q <= ST_SCR_COPY;
        end
        ST_SCR_COPY: begin
          cp_v_q <= (i_q != keep_q);
          if (i_q == keep_q) begin
            state_q <= ST_SCR_FILL;
          end
        end
        ST_SCR_FILL: begin
          if (i_q == total_q - LIN_W'(1)) begin
            state_q <= ST_LOC;
          end
        end
        ST_LOC: begin
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (res_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q      <= item_i.operation;
      char_q    <= item_i.character;
      idx_ok_q  <= idx_ok;
      col_tmp_q <= col_tmp_d;
      row_tmp_q <= row_tmp_d;
      wr_ok_q   <= wr_ok_d;
    end
    if (state_q == ST_SCR_INIT) begin
      total_q <= mac_q;
      keep_q  <= mac_q - LIN_W'(geom_i.ncol);
      i_q     <= '0;
    end else if (state_q == ST_SCR_COPY) begin
      cp_addr_q <= i_q;
      if (i_q != keep_q) begin
        i_q <= i_q + LIN_W'(1);
      end
    end else if (state_q == ST_SCR_FILL) begin
      i_q <= i_q + LIN_W'(1);
    end
  end

  assign res_o.valid           = (state_q == ST_DONE);
  assign res_o.cursor_location = mac_q[LOC_W-1:0];
  assign res_o.cell_value      = ((op_q == OP_READ) && idx_ok_q) ? mem_rdata : '0;
  assign res_o.echoed_char     = (op_q == OP_PUT) ? char_q : '0;

  `TMCW_ASSERT(a_no_write_idle, clk_i, rst_ni, ((state_q == ST_IDLE) |-> !mem_we), "cell write while idle")
  `TMCW_ASSERT(a_copy_in_scroll, clk_i, rst_ni, (cp_v_q |-> (state_q == ST_SCR_COPY)), "copy write outside scroll")
  `TMCW_ASSERT(a_clear_once, clk_i, rst_ni, ((state_q != ST_CLEAR) |=> (state_q != ST_CLEAR)), "clear pass restarted")
  `TMCW_ASSERT_ALWAYS(a_clear_busy, clk_i, ((state_q == ST_CLEAR) |-> !in_ready_o), "input taken during clear")

endmodule

>>> hw/rtl/text_mode_console_writer_top.sv
// Top level of the text-mode console writer: APB registers, output register.
// Depends on tmcw_pkg, tmcw_if and tmcw_engine.
//
//  Channel   Direction  Transaction contents
//  in_chan   sink       operation, character, cell_index
//  out_chan  source     cursor_location, cell_value, echoed_char
//  APB       slave      columns (0x0), rows (0x4), attribute (0x8)
//
// A read_cell transaction goes from idle to the done state, a put through the
// write and location states; both are set by the sequencer passing the cursor
// through the shared multiply-add unit. A put that scrolls adds the scroll
// calc, init, copy and fill states: the single memory write port copies or
// fills one cell a cycle. After reset the cell memory is cleared one cell a
// cycle, and no input transaction is taken meanwhile; APB writes still are.
// A result waits in the output register while the next item is accepted.
module text_mode_console_writer_top import tmcw_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  tmcw_in_if.sink           in_chan_i,
  tmcw_out_if.source        out_chan_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  // Configuration registers, written on the APB access phase.
  logic [COL_W-1:0]  columns_q;
  logic [ROW_W-1:0]  rows_q;
  logic [ATTR_W-1:0] attr_q;
  logic              cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q <= COLUMNS_RST;
      rows_q    <= ROWS_RST;
      attr_q    <= ATTR_RST;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_COLUMNS:   columns_q <= pwdata[COL_W-1:0];
        REG_ROWS:      rows_q    <= pwdata[ROW_W-1:0];
        REG_ATTRIBUTE: attr_q    <= pwdata[ATTR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_COLUMNS:   prdata = APB_DW'(columns_q);
      REG_ROWS:      prdata = APB_DW'(rows_q);
      REG_ATTRIBUTE: prdata = APB_DW'(attr_q);
      default:       prdata = '0;
    endcase
  end

  // Effective screen size: zero counts as one, anything past the storage
  // size is clamped to it.
  geom_t geom;

  always_comb begin
    geom.attr = attr_q;
    if (columns_q == '0) begin
      geom.ncol = COL_W'(1);
    end else if (int'(columns_q) > MAX_COLUMNS) begin
      geom.ncol = COL_W'(MAX_COLUMNS);
    end else begin
      geom.ncol = columns_q;
    end
    if (rows_q == '0) begin
      geom.nrow = ROW_W'(1);
    end else if (int'(rows_q) > MAX_ROWS) begin
      geom.nrow = ROW_W'(MAX_ROWS);
    end else begin
      geom.nrow = rows_q;
    end
  end

  item_t   item;
  result_t res;
  logic    res_ready;

  assign item.operation  = in_chan_i.operation;
  assign item.character  = in_chan_i.character;
  assign item.cell_index = in_chan_i.cell_index;

  tmcw_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .geom_i      (geom),
    .in_valid_i  (in_chan_i.valid),
    .in_ready_o  (in_chan_i.ready),
    .item_i      (item),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register: the engine hands over a result whenever the register
  // is empty or is being emptied in the same cycle.
  logic              out_valid_q;
  logic [LOC_W-1:0]  out_loc_q;
  logic [CELL_W-1:0] out_cell_q;
  logic [CHAR_W-1:0] out_echo_q;

  assign res_ready = !out_valid_q || out_chan_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res.valid) begin
      out_loc_q  <= res.cursor_location;
      out_cell_q <= res.cell_value;
      out_echo_q <= res.echoed_char;
    end
  end

  assign out_chan_o.valid           = out_valid_q;
  assign out_chan_o.cursor_location = out_loc_q;
  assign out_chan_o.cell_value      = out_cell_q;
  assign out_chan_o.echoed_char     = out_echo_q;

endmodule
